// File: src/slbp_pkg.sv
// Shared types, constants and helpers for the status LED blink pattern block.
// No dependencies; used by slbp_csr, slbp_engine and status_led_blink_pattern_top.
package slbp_pkg;

   // Timestamp arithmetic width (elapsed time wraps at 2^TIME_WIDTH), 16..64
   localparam int TIME_WIDTH = 32;
   localparam int MS_WIDTH   = 32;
   localparam int PER_WIDTH  = 16;
   localparam int PAT_WIDTH  = 3;
   localparam int STEP_WIDTH = 3;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   // Pattern codes
   localparam logic [PAT_WIDTH-1:0] PAT_OFF    = 3'd0;
   localparam logic [PAT_WIDTH-1:0] PAT_SLOW   = 3'd1;
   localparam logic [PAT_WIDTH-1:0] PAT_FAST   = 3'd2;
   localparam logic [PAT_WIDTH-1:0] PAT_DOUBLE = 3'd3;
   localparam logic [PAT_WIDTH-1:0] PAT_SOLID  = 3'd4;
   localparam logic [PAT_WIDTH-1:0] PAT_TRIPLE = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PATTERN      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SLOW_PERIOD  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FAST_PERIOD  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DOUBLE_SHORT = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DOUBLE_PAUSE = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TRIPLE_SHORT = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TRIPLE_PAUSE = 3'd6;

   // Reset values of the period registers
   localparam logic [PER_WIDTH-1:0] RST_SLOW_PERIOD  = 16'd1000;
   localparam logic [PER_WIDTH-1:0] RST_FAST_PERIOD  = 16'd200;
   localparam logic [PER_WIDTH-1:0] RST_DOUBLE_SHORT = 16'd150;
   localparam logic [PER_WIDTH-1:0] RST_DOUBLE_PAUSE = 16'd600;
   localparam logic [PER_WIDTH-1:0] RST_TRIPLE_SHORT = 16'd100;
   localparam logic [PER_WIDTH-1:0] RST_TRIPLE_PAUSE = 16'd500;

   // Step boundaries for the multi-blink patterns
   localparam logic [STEP_WIDTH-1:0] DOUBLE_PAUSE_STEP = 3'd4;
   localparam logic [STEP_WIDTH-1:0] TRIPLE_PAUSE_STEP = 3'd6;
   localparam logic [STEP_WIDTH:0]   DOUBLE_WRAP       = 4'd6;

   typedef logic [TIME_WIDTH-1:0] time_type;

   // Configuration seen by the engine
   typedef struct packed {
      logic [PAT_WIDTH-1:0] pattern;
      logic [PER_WIDTH-1:0] slow_period;
      logic [PER_WIDTH-1:0] fast_period;
      logic [PER_WIDTH-1:0] double_short;
      logic [PER_WIDTH-1:0] double_pause;
      logic [PER_WIDTH-1:0] triple_short;
      logic [PER_WIDTH-1:0] triple_pause;
      logic                 step_clr;
   } cfg_type;

   // Timestamp word to internal time width (truncate or zero-extend)
   function automatic time_type time_from_ms(input logic [MS_WIDTH-1:0] ms);
      logic [63:0] wide;
      wide = 64'(ms);
      return wide[TIME_WIDTH-1:0];
   endfunction

endpackage

// File: src/slbp_csr.sv
// Configuration registers of the status LED blink pattern block.
// Depends on slbp_pkg.
module slbp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [slbp_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [slbp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output slbp_pkg::cfg_type                    cfg
);

   logic [slbp_pkg::PAT_WIDTH-1:0] pattern_ff;
   logic [slbp_pkg::PER_WIDTH-1:0] slow_ff, fast_ff, dshort_ff, dpause_ff, tshort_ff, tpause_ff;
   logic                           step_clr_ff, step_clr_in;
   logic [slbp_pkg::PAT_WIDTH-1:0] wr_pattern;

   assign wr_pattern = csr_wdata[slbp_pkg::PAT_WIDTH-1:0];

   // a blink pattern write restarts the step sequence
   always_comb begin
      step_clr_in = 1'b0;
      if (csr_wr_en && csr_index == slbp_pkg::CSR_PATTERN) begin
         step_clr_in = wr_pattern == slbp_pkg::PAT_SLOW || wr_pattern == slbp_pkg::PAT_FAST ||
                       wr_pattern == slbp_pkg::PAT_DOUBLE || wr_pattern == slbp_pkg::PAT_TRIPLE;
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= slbp_pkg::PAT_OFF;
         slow_ff     <= slbp_pkg::RST_SLOW_PERIOD;
         fast_ff     <= slbp_pkg::RST_FAST_PERIOD;
         dshort_ff   <= slbp_pkg::RST_DOUBLE_SHORT;
         dpause_ff   <= slbp_pkg::RST_DOUBLE_PAUSE;
         tshort_ff   <= slbp_pkg::RST_TRIPLE_SHORT;
         tpause_ff   <= slbp_pkg::RST_TRIPLE_PAUSE;
         step_clr_ff <= 1'b0;
      end else begin
         step_clr_ff <= step_clr_in;
         if (csr_wr_en) begin
            case (csr_index)
               slbp_pkg::CSR_PATTERN:      pattern_ff <= wr_pattern;
               slbp_pkg::CSR_SLOW_PERIOD:  slow_ff    <= csr_wdata;
               slbp_pkg::CSR_FAST_PERIOD:  fast_ff    <= csr_wdata;
               slbp_pkg::CSR_DOUBLE_SHORT: dshort_ff  <= csr_wdata;
               slbp_pkg::CSR_DOUBLE_PAUSE: dpause_ff  <= csr_wdata;
               slbp_pkg::CSR_TRIPLE_SHORT: tshort_ff  <= csr_wdata;
               slbp_pkg::CSR_TRIPLE_PAUSE: tpause_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign cfg.pattern      = pattern_ff;
   assign cfg.slow_period  = slow_ff;
   assign cfg.fast_period  = fast_ff;
   assign cfg.double_short = dshort_ff;
   assign cfg.double_pause = dpause_ff;
   assign cfg.triple_short = tshort_ff;
   assign cfg.triple_pause = tpause_ff;
   assign cfg.step_clr     = step_clr_ff;

endmodule

// File: src/slbp_engine.sv
// Blink state (last toggle time, levels, step) and the per-word update logic.
// Depends on slbp_pkg.
module slbp_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  slbp_pkg::cfg_type               cfg,
   input  logic                            fire,
   input  logic [slbp_pkg::MS_WIDTH-1:0]   now_ms,
   output logic                            led_on,
   output logic                            toggled
);

   slbp_pkg::time_type              last_ff, last_in, now_t, elapsed;
   logic                            blink_ff, blink_in;
   logic                            pin_ff, pin_in;
   logic [slbp_pkg::STEP_WIDTH-1:0] step_ff, step_in, step_adv, step_cur;
   logic [slbp_pkg::STEP_WIDTH:0]   step_sum;
   logic [slbp_pkg::PER_WIDTH-1:0]  period;
   logic                            blinking, tog;

   // a pending step clear already applies to a word that fires this cycle
   assign step_cur = cfg.step_clr ? '0 : step_ff;

   assign now_t    = slbp_pkg::time_from_ms(now_ms);
   assign elapsed  = now_t - last_ff;
   assign step_sum = {1'b0, step_cur} + 1'b1;

   // period selection and step advance per pattern
   always_comb begin
      period   = '0;
      blinking = 1'b1;
      step_adv = step_cur;
      case (cfg.pattern)
         slbp_pkg::PAT_SLOW: period = cfg.slow_period;
         slbp_pkg::PAT_FAST: period = cfg.fast_period;
         slbp_pkg::PAT_DOUBLE: begin
            period = (step_cur < slbp_pkg::DOUBLE_PAUSE_STEP) ? cfg.double_short
                                                               : cfg.double_pause;
            // mod 6, also folds stray steps 6 and 7
            step_adv = (step_sum >= slbp_pkg::DOUBLE_WRAP)
                       ? slbp_pkg::STEP_WIDTH'(step_sum - slbp_pkg::DOUBLE_WRAP)
                       : step_sum[slbp_pkg::STEP_WIDTH-1:0];
         end
         slbp_pkg::PAT_TRIPLE: begin
            period = (step_cur < slbp_pkg::TRIPLE_PAUSE_STEP) ? cfg.triple_short
                                                               : cfg.triple_pause;
            step_adv = step_sum[slbp_pkg::STEP_WIDTH-1:0];
         end
         default: blinking = 1'b0;
      endcase
   end

   assign tog = blinking && (elapsed >= slbp_pkg::TIME_WIDTH'(period));

   // next state
   always_comb begin
      last_in  = last_ff;
      blink_in = blink_ff;
      pin_in   = pin_ff;
      step_in  = step_cur;
      if (fire) begin
         if (cfg.pattern == slbp_pkg::PAT_SOLID) begin
            pin_in = 1'b1;
         end else if (!blinking) begin
            pin_in = 1'b0;
         end
         if (tog) begin
            blink_in = ~blink_ff;
            pin_in   = ~blink_ff;
            last_in  = now_t;
            step_in  = step_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         blink_ff <= 1'b0;
         pin_ff   <= 1'b0;
         step_ff  <= '0;
      end else begin
         last_ff  <= last_in;
         blink_ff <= blink_in;
         pin_ff   <= pin_in;
         step_ff  <= step_in;
      end
   end

   assign led_on  = pin_in;
   assign toggled = fire && tog;

endmodule

// File: src/status_led_blink_pattern_top.sv
// Top level of the status LED blink pattern generator: input register,
// engine and result register. Depends on slbp_pkg, slbp_csr, slbp_engine.
//
//   channel  ports         dir  handshake
//   request  req_now_ms    in   req_valid / req_ready
//   response rsp_led_on,   out  rsp_valid / rsp_ready
//            rsp_toggled
//   config   csr_*         in   csr_wr_en, no wait
//
// One word per clock unless rsp_ready stalls; a word passes the input register,
// then the result register after the update logic, on its way to rsp_valid.
// Synchronous reset clears control state, the blink state and the config registers, not payload.
// A stall on rsp_ready holds the result register; the input register keeps
// taking a word while the result waits, so req_ready drops only when both hold.
module status_led_blink_pattern_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [slbp_pkg::MS_WIDTH-1:0]        req_now_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_led_on,
   output logic                                 rsp_toggled,
   input  logic                                 csr_wr_en,
   input  logic [slbp_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [slbp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   slbp_pkg::cfg_type              cfg;
   logic                           s1_valid_ff, s1_valid_in;
   logic [slbp_pkg::MS_WIDTH-1:0]  s1_now_ff;
   logic                           out_valid_ff, out_valid_in;
   logic                           out_led_ff, out_tog_ff;
   logic                           advance, fire, led_c, tog_c;

   slbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // pipeline flow control
   assign advance     = !out_valid_ff || rsp_ready;
   assign fire        = s1_valid_ff && advance;
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   slbp_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .fire    (fire),
      .now_ms  (s1_now_ff),
      .led_on  (led_c),
      .toggled (tog_c)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_now_ff <= req_now_ms;
      end
      if (fire) begin
         out_led_ff <= led_c;
         out_tog_ff <= tog_c;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_led_on  = out_led_ff;
   assign rsp_toggled = out_tog_ff;

   // a stalled input word stays put
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_now_ff))
      else $error("input word lost or changed while stalled");

   // solid pattern drives the pin high without toggling
   a_solid: assert property (@(posedge clock) disable iff (reset)
      fire && cfg.pattern == slbp_pkg::PAT_SOLID |=> rsp_valid && rsp_led_on && !rsp_toggled)
      else $error("solid pattern result wrong");

   // off and unused codes drive the pin low without toggling
   a_off: assert property (@(posedge clock) disable iff (reset)
      fire && (cfg.pattern == slbp_pkg::PAT_OFF || cfg.pattern > slbp_pkg::PAT_TRIPLE)
      |=> rsp_valid && !rsp_led_on && !rsp_toggled)
      else $error("off pattern result wrong");

   // the result register only drains through an accepted word
   a_drain: assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> $past(rsp_ready))
      else $error("result dropped without handshake");

endmodule

// File: test/slbp_checker.sv
// Checker for the status LED blink pattern block: follows register writes,
// predicts the LED word for each accepted timestamp word and compares responses.
// Depends on slbp_pkg only; instantiated by the testbench top beside the block.
module slbp_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [slbp_pkg::MS_WIDTH-1:0]       req_now_ms,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_led_on,
   input  logic                                rsp_toggled,
   input  logic                                csr_wr_en,
   input  logic [slbp_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [slbp_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output int                                  mismatch_count,
   output int                                  words_pending,
   output int                                  words_checked,
   output int                                  toggle_count
);

   // Step counts of the multi-blink patterns
   localparam int DOUBLE_STEPS = 6;
   localparam int TRIPLE_STEPS = 8;

   typedef struct packed {
      logic led_on;
      logic toggled;
   } led_word_type;

   // Expected LED words, oldest first
   led_word_type led_words_due[$];

   // Shadow registers
   logic [slbp_pkg::PAT_WIDTH-1:0] pattern_reg;
   logic [slbp_pkg::PER_WIDTH-1:0] slow_reg, fast_reg;
   logic [slbp_pkg::PER_WIDTH-1:0] dshort_reg, dpause_reg, tshort_reg, tpause_reg;

   // Shadow blink state
   slbp_pkg::time_type              last_toggle;
   logic                            blink_level;
   logic                            pin_level;
   logic [slbp_pkg::STEP_WIDTH-1:0] blink_step;

   int errors  = 0;
   int checked = 0;
   int toggles = 0;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   // Advance the blink state by one timestamp and return the LED word
   function automatic led_word_type next_led_word(input logic [slbp_pkg::MS_WIDTH-1:0] ms);
      slbp_pkg::time_type             now_t;
      slbp_pkg::time_type             elapsed;
      logic [slbp_pkg::PER_WIDTH-1:0] period;
      logic                           blinking;
      int                             wrap;
      led_word_type                   w;
      now_t    = slbp_pkg::time_type'(ms);
      elapsed  = now_t - last_toggle;
      period   = '0;
      blinking = 1'b1;
      wrap     = 0;
      case (pattern_reg)
         slbp_pkg::PAT_SLOW: period = slow_reg;
         slbp_pkg::PAT_FAST: period = fast_reg;
         slbp_pkg::PAT_DOUBLE: begin
            period = (blink_step < slbp_pkg::DOUBLE_PAUSE_STEP) ? dshort_reg : dpause_reg;
            wrap   = DOUBLE_STEPS;
         end
         slbp_pkg::PAT_TRIPLE: begin
            period = (blink_step < slbp_pkg::TRIPLE_PAUSE_STEP) ? tshort_reg : tpause_reg;
            wrap   = TRIPLE_STEPS;
         end
         slbp_pkg::PAT_SOLID: begin
            blinking  = 1'b0;
            pin_level = 1'b1;
         end
         // off and the spare codes drive the pin low
         default: begin
            blinking  = 1'b0;
            pin_level = 1'b0;
         end
      endcase
      w.toggled = 1'b0;
      if (blinking && elapsed >= slbp_pkg::time_type'(period)) begin
         blink_level = ~blink_level;
         pin_level   = blink_level;
         last_toggle = now_t;
         if (wrap != 0)
            blink_step = slbp_pkg::STEP_WIDTH'((int'(blink_step) + 1) % wrap);
         w.toggled = 1'b1;
      end
      w.led_on = pin_level;
      return w;
   endfunction

   always @(posedge clock) begin : watch
      led_word_type got, due;
      if (reset) begin
         led_words_due.delete();
         pattern_reg = slbp_pkg::PAT_OFF;
         slow_reg    = slbp_pkg::RST_SLOW_PERIOD;
         fast_reg    = slbp_pkg::RST_FAST_PERIOD;
         dshort_reg  = slbp_pkg::RST_DOUBLE_SHORT;
         dpause_reg  = slbp_pkg::RST_DOUBLE_PAUSE;
         tshort_reg  = slbp_pkg::RST_TRIPLE_SHORT;
         tpause_reg  = slbp_pkg::RST_TRIPLE_PAUSE;
         last_toggle = '0;
         blink_level = 1'b0;
         pin_level   = 1'b0;
         blink_step  = '0;
      end else begin
         // register writes; a blink pattern write restarts the step counter
         if (csr_wr_en) begin
            case (csr_index)
               slbp_pkg::CSR_PATTERN: begin
                  pattern_reg = csr_wdata[slbp_pkg::PAT_WIDTH-1:0];
                  if (pattern_reg == slbp_pkg::PAT_SLOW || pattern_reg == slbp_pkg::PAT_FAST ||
                      pattern_reg == slbp_pkg::PAT_DOUBLE ||
                      pattern_reg == slbp_pkg::PAT_TRIPLE)
                     blink_step = '0;
               end
               slbp_pkg::CSR_SLOW_PERIOD:  slow_reg   = csr_wdata[slbp_pkg::PER_WIDTH-1:0];
               slbp_pkg::CSR_FAST_PERIOD:  fast_reg   = csr_wdata[slbp_pkg::PER_WIDTH-1:0];
               slbp_pkg::CSR_DOUBLE_SHORT: dshort_reg = csr_wdata[slbp_pkg::PER_WIDTH-1:0];
               slbp_pkg::CSR_DOUBLE_PAUSE: dpause_reg = csr_wdata[slbp_pkg::PER_WIDTH-1:0];
               slbp_pkg::CSR_TRIPLE_SHORT: tshort_reg = csr_wdata[slbp_pkg::PER_WIDTH-1:0];
               slbp_pkg::CSR_TRIPLE_PAUSE: tpause_reg = csr_wdata[slbp_pkg::PER_WIDTH-1:0];
               default: ;
            endcase
         end

         // response side: compare against the oldest expected word
         if (rsp_valid && rsp_ready) begin
            got.led_on  = rsp_led_on;
            got.toggled = rsp_toggled;
            if (led_words_due.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               due = led_words_due.pop_front();
               if (got.led_on !== due.led_on)
                  report_mismatch($sformatf("word %0d led_on %b, expected %b",
                                            checked, got.led_on, due.led_on));
               if (got.toggled !== due.toggled)
                  report_mismatch($sformatf("word %0d toggled %b, expected %b",
                                            checked, got.toggled, due.toggled));
               checked++;
            end
         end

         // request side: predict
         if (req_valid && req_ready) begin
            due = next_led_word(req_now_ms);
            if (due.toggled)
               toggles++;
            led_words_due.push_back(due);
         end
      end
      mismatch_count <= errors;
      words_pending  <= led_words_due.size();
      words_checked  <= checked;
      toggle_count   <= toggles;
   end

endmodule

// File: test/testbench.sv
// Testbench top for status_led_blink_pattern_top: clock, reset, stimulus on the
// request and register ports, random response back-pressure and the verdict.
// Depends on slbp_pkg, the block under test and slbp_checker.
module testbench;

   localparam int RANDOM_WORDS     = 1500;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = 8;

   // Pattern codes the block leaves unused, and the unused register index
   localparam logic [slbp_pkg::PAT_WIDTH-1:0]     PAT_SPARE_A = 3'd6;
   localparam logic [slbp_pkg::PAT_WIDTH-1:0]     PAT_SPARE_B = 3'd7;
   localparam logic [slbp_pkg::CSR_IDX_WIDTH-1:0] CSR_UNUSED  = 3'd7;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   logic [slbp_pkg::MS_WIDTH-1:0]       req_now_ms  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   logic                                rsp_led_on;
   logic                                rsp_toggled;
   logic                                csr_wr_en   = 1'b0;
   logic [slbp_pkg::CSR_IDX_WIDTH-1:0]  csr_index   = '0;
   logic [slbp_pkg::CSR_DATA_WIDTH-1:0] csr_wdata   = '0;

   int   req_idle_pct   = 0;
   int   rsp_idle_pct   = 0;
   logic long_hold_go   = 1'b0;
   logic long_hold_done = 1'b0;
   int   hold_left      = 0;
   int   cycle_count    = 0;

   int mismatches, pending, checked, toggles;

   // Stimulus-side copy of what was written, used only to size time steps
   logic [slbp_pkg::PAT_WIDTH-1:0] pattern_now = slbp_pkg::PAT_OFF;
   logic [slbp_pkg::PER_WIDTH-1:0] period_now [1:6];
   logic [slbp_pkg::MS_WIDTH-1:0]  stamp;
   int                             phases = 0;

   status_led_blink_pattern_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_now_ms  (req_now_ms),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_led_on  (rsp_led_on),
      .rsp_toggled (rsp_toggled),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   slbp_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_on     (rsp_led_on),
      .rsp_toggled    (rsp_toggled),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .words_pending  (pending),
      .words_checked  (checked),
      .toggle_count   (toggles)
   );

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_hold_go && !long_hold_done) begin
         rsp_ready      <= 1'b0;
         hold_left      <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Drop valid and wait until every expected word has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write, made only while the block is idle
   task automatic write_reg(input logic [slbp_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [slbp_pkg::CSR_DATA_WIDTH-1:0] data);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == slbp_pkg::CSR_PATTERN)
         pattern_now = data[slbp_pkg::PAT_WIDTH-1:0];
      else if (idx != CSR_UNUSED)
         period_now[int'(idx)] = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Offer one timestamp word, with a random gap in front of it
   task automatic send_stamp(input logic [slbp_pkg::MS_WIDTH-1:0] ms);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid  <= 1'b1;
      req_now_ms <= ms;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Period value: first two phases at the extremes, then mostly short periods
   function automatic logic [slbp_pkg::PER_WIDTH-1:0] pick_period(input int phase);
      int r;
      r = $urandom_range(0, 99);
      if (phase == 0)
         return 16'd1;
      if (phase == 1)
         return 16'hFFFF;
      if (r < 3)
         return 16'd0;
      if (r < 10)
         return 16'd1;
      if (r < 17)
         return 16'hFFFF;
      if (r < 60)
         return slbp_pkg::PER_WIDTH'($urandom_range(1, 20));
      return slbp_pkg::PER_WIDTH'($urandom_range(1, 2000));
   endfunction

   // Mostly blink patterns, the rest off, solid and the spare codes
   function automatic logic [slbp_pkg::PAT_WIDTH-1:0] pick_pattern();
      logic [slbp_pkg::PAT_WIDTH-1:0] blink_set [4];
      logic [slbp_pkg::PAT_WIDTH-1:0] still_set [4];
      blink_set[0] = slbp_pkg::PAT_SLOW;
      blink_set[1] = slbp_pkg::PAT_FAST;
      blink_set[2] = slbp_pkg::PAT_DOUBLE;
      blink_set[3] = slbp_pkg::PAT_TRIPLE;
      still_set[0] = slbp_pkg::PAT_OFF;
      still_set[1] = slbp_pkg::PAT_SOLID;
      still_set[2] = PAT_SPARE_A;
      still_set[3] = PAT_SPARE_B;
      if ($urandom_range(0, 99) < 70)
         return blink_set[$urandom_range(0, 3)];
      return still_set[$urandom_range(0, 3)];
   endfunction

   // Next timestamp: steps around the active period, with rare random jumps
   function automatic logic [slbp_pkg::MS_WIDTH-1:0] next_stamp(
      input logic [slbp_pkg::MS_WIDTH-1:0] prev);
      int scale;
      if ($urandom_range(0, 99) < 4)
         return slbp_pkg::MS_WIDTH'($urandom);
      case (pattern_now)
         slbp_pkg::PAT_SLOW:   scale = period_now[int'(slbp_pkg::CSR_SLOW_PERIOD)];
         slbp_pkg::PAT_FAST:   scale = period_now[int'(slbp_pkg::CSR_FAST_PERIOD)];
         slbp_pkg::PAT_DOUBLE: scale = $urandom_range(0, 1)
                                       ? period_now[int'(slbp_pkg::CSR_DOUBLE_SHORT)]
                                       : period_now[int'(slbp_pkg::CSR_DOUBLE_PAUSE)];
         slbp_pkg::PAT_TRIPLE: scale = $urandom_range(0, 1)
                                       ? period_now[int'(slbp_pkg::CSR_TRIPLE_SHORT)]
                                       : period_now[int'(slbp_pkg::CSR_TRIPLE_PAUSE)];
         default:              scale = 1000;
      endcase
      return prev + slbp_pkg::MS_WIDTH'($urandom_range(0, scale + scale / 2 + 1));
   endfunction

   initial begin : stimulus
      int random_sent;
      int count;
      logic [slbp_pkg::CSR_DATA_WIDTH-slbp_pkg::PAT_WIDTH-1:0] high_bits;
      period_now[int'(slbp_pkg::CSR_SLOW_PERIOD)]  = slbp_pkg::RST_SLOW_PERIOD;
      period_now[int'(slbp_pkg::CSR_FAST_PERIOD)]  = slbp_pkg::RST_FAST_PERIOD;
      period_now[int'(slbp_pkg::CSR_DOUBLE_SHORT)] = slbp_pkg::RST_DOUBLE_SHORT;
      period_now[int'(slbp_pkg::CSR_DOUBLE_PAUSE)] = slbp_pkg::RST_DOUBLE_PAUSE;
      period_now[int'(slbp_pkg::CSR_TRIPLE_SHORT)] = slbp_pkg::RST_TRIPLE_SHORT;
      period_now[int'(slbp_pkg::CSR_TRIPLE_PAUSE)] = slbp_pkg::RST_TRIPLE_PAUSE;
      random_sent = 0;

      repeat (2) @(posedge clock);
      reset        <= 1'b0;
      req_idle_pct <= 24;
      rsp_idle_pct <= 51;

      // Off after reset, both timestamp extremes
      send_stamp('0);
      send_stamp('1);
      // Solid, then the spare codes which act as off
      write_reg(slbp_pkg::CSR_PATTERN, slbp_pkg::PAT_SOLID);
      send_stamp(32'd5);
      write_reg(slbp_pkg::CSR_PATTERN, PAT_SPARE_A);
      send_stamp(32'd6);
      write_reg(slbp_pkg::CSR_PATTERN, PAT_SPARE_B);
      send_stamp(32'd7);
      // Zero period toggles on every word, even with no time elapsed
      write_reg(slbp_pkg::CSR_SLOW_PERIOD, 16'd0);
      write_reg(slbp_pkg::CSR_PATTERN, slbp_pkg::PAT_SLOW);
      send_stamp(32'd100);
      send_stamp(32'd100);
      // Largest period: one short of it, then exactly it
      write_reg(slbp_pkg::CSR_SLOW_PERIOD, 16'hFFFF);
      write_reg(slbp_pkg::CSR_PATTERN, slbp_pkg::PAT_SLOW);
      send_stamp(32'd100 + 32'd65534);
      send_stamp(32'd100 + 32'd65535);
      // Shortest fast period and elapsed time across the timestamp wrap
      write_reg(slbp_pkg::CSR_FAST_PERIOD, 16'd1);
      write_reg(slbp_pkg::CSR_PATTERN, slbp_pkg::PAT_FAST);
      send_stamp('1);
      send_stamp('1);
      send_stamp('0);
      // Double blink: four short toggles, pause, wrap back to short
      write_reg(slbp_pkg::CSR_DOUBLE_SHORT, 16'd2);
      write_reg(slbp_pkg::CSR_DOUBLE_PAUSE, 16'd5);
      write_reg(slbp_pkg::CSR_PATTERN, slbp_pkg::PAT_DOUBLE);
      for (int k = 1; k <= 4; k++)
         send_stamp(slbp_pkg::MS_WIDTH'(2 * k));
      send_stamp(32'd12);
      send_stamp(32'd13);
      send_stamp(32'd18);
      // Triple blink: six short toggles, then a pause step
      write_reg(slbp_pkg::CSR_TRIPLE_SHORT, 16'd1);
      write_reg(slbp_pkg::CSR_TRIPLE_PAUSE, 16'd3);
      write_reg(slbp_pkg::CSR_PATTERN, slbp_pkg::PAT_TRIPLE);
      for (int k = 19; k <= 24; k++)
         send_stamp(slbp_pkg::MS_WIDTH'(k));
      send_stamp(32'd27);
      // Write to the unused index is dropped; off pulls the pin low
      write_reg(CSR_UNUSED, 16'hFFFF);
      write_reg(slbp_pkg::CSR_PATTERN, slbp_pkg::PAT_OFF);
      send_stamp(32'd30);

      // Random phases: new settings, then a run of timestamps
      stamp = 32'd30;
      while (random_sent < RANDOM_WORDS) begin
         if (random_sent >= 2 * RANDOM_WORDS / 3) begin
            req_idle_pct <= 0;
            rsp_idle_pct <= 0;
         end else if (random_sent >= RANDOM_WORDS / 3) begin
            req_idle_pct <= 51;
            rsp_idle_pct <= 24;
         end
         for (int idx = 1; idx <= 6; idx++)
            write_reg(slbp_pkg::CSR_IDX_WIDTH'(idx), pick_period(phases));
         if ($urandom_range(0, 99) < 15)
            write_reg(CSR_UNUSED, slbp_pkg::CSR_DATA_WIDTH'($urandom));
         // skipping the pattern write keeps the step counter running
         if (phases < 2 || $urandom_range(0, 99) < 85) begin
            high_bits = $urandom_range(0, 3) == 0
                        ? (slbp_pkg::CSR_DATA_WIDTH-slbp_pkg::PAT_WIDTH)'($urandom) : '0;
            write_reg(slbp_pkg::CSR_PATTERN, {high_bits, pick_pattern()});
         end
         if ($urandom_range(0, 3) == 0)
            stamp = 32'hFFFF_FFFF - slbp_pkg::MS_WIDTH'($urandom_range(0, 200000));
         // long receiver hold-off once the no-idle stretch has begun
         if (random_sent >= 2 * RANDOM_WORDS / 3 + 50 && !long_hold_go)
            long_hold_go <= 1'b1;
         count = $urandom_range(40, 160);
         repeat (count) begin
            stamp = next_stamp(stamp);
            send_stamp(stamp);
            random_sent++;
         end
         phases++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d timestamp words: a directed opening and %0d random setting phases",
               checked, phases);
      $display("%0d words toggled the LED; idling swapped sides, then none with a %0d-cycle hold",
               toggles, LONG_HOLD_CYCLES);
      if (mismatches == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: status_led_blink_pattern_top.f
src/slbp_pkg.sv
src/slbp_csr.sv
src/slbp_engine.sv
src/status_led_blink_pattern_top.sv
test/slbp_checker.sv
test/testbench.sv
